FILE: hdl/csrsd_pkg.sv
`default_nettype none
package csrsd_pkg;

	localparam int OP_W   = 2;
	localparam int COL_W  = 10;
	localparam int LANE_W = 3;
	localparam int VAL_W  = 32;
	localparam int ROW_W  = 16;
	localparam int SUM_W  = 48;
	localparam int PROD_W = 2 * VAL_W;
	localparam int FRAC_W = 16;
	// wide enough to hold any column index that a RAM depth may need
	localparam int COL_EXT_W = 17;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD   = 2'd0,
		OP_NZ     = 2'd1,
		OP_NZ_END = 2'd2,
		OP_CLOSE  = 2'd3
	} op_t;

	// control broadcast from the sequencer to every lane cell
	typedef struct packed {
		logic advance;
		logic load_en;
		logic nz_s1;
		logic nz_s2;
		logic close_s2;
		logic drain_load;
		logic drain_shift;
	} cell_ctl_t;

	function automatic logic signed [SUM_W-1:0] sat_add(
		input logic signed [SUM_W-1:0] acc,
		input logic signed [SUM_W-1:0] p
	);
		logic signed [SUM_W:0] s;
		logic signed [SUM_W-1:0] r;
		s = {acc[SUM_W-1], acc} + {p[SUM_W-1], p};
		if (s[SUM_W] != s[SUM_W-1]) begin
			r = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end else begin
			r = s[SUM_W-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: hdl/csrsd_in_if.sv
`default_nettype none
interface csrsd_in_if
	import csrsd_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [COL_W-1:0]  col;
	logic [LANE_W-1:0] lane;
	logic signed [VAL_W-1:0] value;
	logic [ROW_W-1:0]  row;

	modport source (output valid, op, col, lane, value, row, input ready);
	modport sink (input valid, op, col, lane, value, row, output ready);
endinterface
`default_nettype wire

FILE: hdl/csrsd_out_if.sv
`default_nettype none
interface csrsd_out_if
	import csrsd_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [ROW_W-1:0]  out_row;
	logic [LANE_W-1:0] out_lane;
	logic signed [SUM_W-1:0] sum;
	logic              last;

	modport source (output valid, out_row, out_lane, sum, last, input ready);
	modport sink (input valid, out_row, out_lane, sum, last, output ready);
endinterface
`default_nettype wire

FILE: hdl/csrsd_ram.sv
`default_nettype none
module csrsd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

FILE: hdl/csrsd_cell.sv
`default_nettype none
module csrsd_cell
	import csrsd_pkg::*;
#(
	parameter int LANE     = 0,
	parameter int MAX_COLS = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire cell_ctl_t                ctl,
	input  wire logic [COL_W-1:0]         col,
	input  wire logic [LANE_W-1:0]        lane,
	input  wire logic signed [VAL_W-1:0]  wdata,
	input  wire logic signed [VAL_W-1:0]  value_s1,
	input  wire logic signed [SUM_W-1:0]  drain_in,
	output logic signed [SUM_W-1:0]       drain_out
);

	localparam int AW = $clog2(MAX_COLS);

	logic [COL_EXT_W-1:0]    col_ext;
	logic                    wr_en;
	logic signed [VAL_W-1:0] w_s1;
	logic signed [PROD_W-1:0] prod_full;
	logic signed [SUM_W-1:0] prod_s2;
	logic signed [SUM_W-1:0] acc_q;
	logic signed [SUM_W-1:0] sum_next;
	logic signed [SUM_W-1:0] drain_q;

	assign col_ext = COL_EXT_W'(col);
	assign wr_en   = ctl.load_en && (int'(lane) == LANE);

	// this lane's slice of the vector store, one word per column
	csrsd_ram #(
		.WIDTH (VAL_W),
		.DEPTH (MAX_COLS)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (col_ext[AW-1:0]),
		.wr_data (wdata),
		.rd_en   (ctl.advance),
		.rd_addr (col_ext[AW-1:0]),
		.rd_data (w_s1)
	);

	assign prod_full = value_s1 * w_s1;

	always_ff @(posedge clk) begin
		if (ctl.advance) begin
			// Q32.32 -> Q32.16, floor
			prod_s2 <= ctl.nz_s1 ? prod_full[PROD_W-1:FRAC_W] : '0;
		end
	end

	assign sum_next = sat_add(acc_q, prod_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.advance) begin
			if (ctl.close_s2) begin
				acc_q <= '0;
			end else if (ctl.nz_s2) begin
				acc_q <= sum_next;
			end
		end
	end

	// drain chain toward lane 0
	always_ff @(posedge clk) begin
		if (ctl.drain_load) begin
			drain_q <= sum_next;
		end else if (ctl.drain_shift) begin
			drain_q <= drain_in;
		end
	end

	assign drain_out = drain_q;

endmodule
`default_nettype wire

FILE: hdl/csr_sparse_times_dense_batch.sv
// Pipeline: a row-ending item passes stages s1 and s2, then loads the lane drain
// registers, which present lane 0 first; other lanes follow one per cycle while
// rsp.ready is high. Throughput: one item per cycle, but a close waits in s2 while
// the drain chain still holds a row; all BATCH lanes leave through one output port.
// Reset: pipeline valids, drain count and lane accumulators clear at once.
// Vector store contents are undefined until loaded; there is no clearing pass.
`default_nettype none
module csr_sparse_times_dense_batch
	import csrsd_pkg::*;
#(
	parameter int BATCH    = 8,
	parameter int MAX_COLS = 1024
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	csrsd_in_if.sink     req,
	csrsd_out_if.source  rsp
);

	localparam int CW = $clog2(BATCH + 1);

	cell_ctl_t ctl;
	logic      accept;
	logic      drain_free;
	op_t       op_in;
	logic      col_ok;

	logic                    vld_s1;
	op_t                     op_s1;
	logic                    colok_s1;
	logic signed [VAL_W-1:0] value_s1;
	logic [ROW_W-1:0]        row_s1;

	logic                    vld_s2;
	op_t                     op_s2;
	logic [ROW_W-1:0]        row_s2;

	logic [CW-1:0]           drain_cnt_q;
	logic [ROW_W-1:0]        drain_row_q;

	logic signed [SUM_W-1:0] drain_w [BATCH+1];

	assign op_in  = op_t'(req.op);
	assign col_ok = int'(req.col) < MAX_COLS;

	assign drain_free = (drain_cnt_q == '0) || ((drain_cnt_q == CW'(1)) && rsp.ready);

	always_comb begin
		ctl.nz_s1    = vld_s1 && colok_s1 && ((op_s1 == OP_NZ) || (op_s1 == OP_NZ_END));
		ctl.nz_s2    = vld_s2 && ((op_s2 == OP_NZ) || (op_s2 == OP_NZ_END));
		ctl.close_s2 = vld_s2 && ((op_s2 == OP_NZ_END) || (op_s2 == OP_CLOSE));
		// a close waits in the last stage until the drain chain can take it
		ctl.advance     = !ctl.close_s2 || drain_free;
		ctl.drain_load  = ctl.close_s2 && ctl.advance;
		ctl.drain_shift = rsp.valid && rsp.ready;
		ctl.load_en     = accept && (op_in == OP_LOAD) && col_ok;
	end

	assign req.ready = ctl.advance;
	assign accept    = req.valid && ctl.advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (ctl.advance) begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.advance) begin
			op_s1    <= op_in;
			colok_s1 <= col_ok;
			value_s1 <= req.value;
			row_s1   <= req.row;
			op_s2    <= op_s1;
			row_s2   <= row_s1;
		end
		if (ctl.drain_load) begin
			drain_row_q <= row_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_cnt_q <= '0;
		end else if (ctl.drain_load) begin
			drain_cnt_q <= CW'(BATCH);
		end else if (ctl.drain_shift) begin
			drain_cnt_q <= drain_cnt_q - CW'(1);
		end
	end

	assign drain_w[BATCH] = '0;

	for (genvar k = 0; k < BATCH; k++) begin : g_lane
		csrsd_cell #(
			.LANE     (k),
			.MAX_COLS (MAX_COLS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.col       (req.col),
			.lane      (req.lane),
			.wdata     (req.value),
			.value_s1  (value_s1),
			.drain_in  (drain_w[k+1]),
			.drain_out (drain_w[k])
		);
	end

	assign rsp.valid    = drain_cnt_q != '0;
	assign rsp.out_row  = drain_row_q;
	assign rsp.out_lane = LANE_W'(BATCH - int'(drain_cnt_q));
	assign rsp.sum      = drain_w[0];
	assign rsp.last     = drain_cnt_q == CW'(1);

	// a new row only enters the drain chain once the previous one has left
	a_drain_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.drain_load |-> ((drain_cnt_q == '0) || ((drain_cnt_q == CW'(1)) && rsp.ready)))
		else $error("drain chain overwritten while results pending");

	// input stalls only behind a pending row close
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> (vld_s2 && ctl.close_s2 && rsp.valid))
		else $error("input stalled without a pending close");

	// after the last lane is taken the chain is empty unless a new row was loaded
	a_last_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.ready && rsp.last && !ctl.drain_load) |=> !rsp.valid)
		else $error("results left after last lane");

endmodule
`default_nettype wire
